/* hdl/lpc_pkg.sv */
package lpc_pkg;

    localparam int PIX_ADDR_W = 19;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RANGE_SQ = 1'b0,
        CFG_MIN_FORWARD  = 1'b1
    } cfg_index_t;

    localparam logic [31:0] MAX_RANGE_SQ_RESET = 32'd26214400;
    localparam logic [30:0] MIN_FORWARD_RESET  = 31'd655;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_POINT = 1'b1
    } mode_t;

    typedef struct packed {
        logic                  mode;
        logic [PIX_ADDR_W-1:0] pixel_addr;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic signed [31:0]    sensor_x;
        logic signed [31:0]    sensor_y;
        logic signed [31:0]    sensor_z;
        logic signed [31:0]    map_x;
        logic signed [31:0]    map_y;
        logic signed [31:0]    map_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
    } out_item_t;

    typedef logic signed [63:0] coef_t;

    // Camera matrix in Q16.16, rows are column, row and depth.
    localparam coef_t CAM_00 = 64'sd21798735;
    localparam coef_t CAM_01 = -64'sd40326884;
    localparam coef_t CAM_02 = -64'sd93642;
    localparam coef_t CAM_10 = 64'sd16532094;
    localparam coef_t CAM_11 = 64'sd165951;
    localparam coef_t CAM_12 = -64'sd40445191;
    localparam coef_t CAM_20 = 64'sd65534;
    localparam coef_t CAM_21 = 64'sd522;
    localparam coef_t CAM_22 = -64'sd181;
    localparam coef_t CAM_OFF_0 = -64'sd6826189 * 64'sd65536;
    localparam coef_t CAM_OFF_1 = -64'sd7096864 * 64'sd65536;
    localparam coef_t CAM_OFF_2 = -64'sd19127 * 64'sd65536;

endpackage

/* hdl/lpc_ram.sv */
module lpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 307200
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

/* hdl/lpc_div.sv */
module lpc_div #(
    parameter int QW = 10
) (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   num,
    input  logic [63:0]   den,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int RW = 64 + QW;

    logic [RW-1:0] rem_reg [QW];
    logic [63:0]   den_reg [QW];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= RW'(num) >= (RW'(den) << QW);
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_stage
        logic [RW-1:0] sub;
        logic          ge;

        assign sub = RW'(den_reg[s-1]) << (QW - s);
        assign ge  = rem_reg[s-1] >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s]   <= q_reg[s-1] | (QW'(ge) << (QW - s));
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end

        if (s < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? rem_reg[s-1] - sub : rem_reg[s-1];
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign quo = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

/* hdl/lidar_point_colorizer.sv */
// Path: an accepted item passes the product, sum and magnitude stages, the divider
// pipeline whose quotient width is QW, the frame store read and the result register.
// Throughput: one item per cycle while the skid register is empty; the divider and
// frame store are fully pipelined. A stalled result moves into a one-entry skid
// register, and the input stalls only while that register is full.
// Reset clears the valid bits and loads both configuration registers with their reset
// values; the frame store keeps whatever it held.
module lidar_point_colorizer #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  lpc_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lpc_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import lpc_pkg::*;

    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int XW    = AW > PIX_ADDR_W ? AW : PIX_ADDR_W;
    localparam int QWC   = $clog2(IMAGE_WIDTH);
    localparam int QWR   = $clog2(IMAGE_HEIGHT);
    localparam int QWM   = QWC > QWR ? QWC : QWR;
    localparam int QW    = QWM > 1 ? QWM : 1;
    localparam int L     = QW + 1;

    typedef struct packed {
        logic          valid;
        logic          is_pt;
        logic          wr_ok;
        logic          fwd_ok;
        logic          rng_ok;
        logic          dnz;
        logic          neg_c;
        logic          neg_r;
        logic [AW-1:0] wa;
        logic [23:0]   rgb;
        logic [95:0]   map;
    } side_t;

    logic        adv;
    logic [31:0] max_range_sq_reg;
    logic [30:0] min_forward_reg;

    side_t a_side_reg, a_side_next;
    side_t b_side_reg, c_side_reg, c_side_next, d_side;
    side_t dl_reg [L];

    logic signed [63:0] p_reg [9];
    logic signed [63:0] p_next [9];
    logic [63:0] sq_reg [3];
    logic [63:0] sq_next [3];

    logic signed [63:0] y0_reg, y1_reg, yd_reg;
    logic [63:0]        range_reg;
    logic [63:0]        abs_c_reg, abs_r_reg, abs_d_reg;

    logic [QW-1:0] q_c, q_r;
    logic          ovf_c, ovf_r;

    logic          e_valid_reg, e_we_reg, e_pt_reg;
    logic [AW-1:0] e_addr_reg;
    logic [23:0]   e_rgb_reg;
    logic [95:0]   e_map_reg;
    logic          f_pt_reg;
    logic [95:0]   f_map_reg;
    logic [23:0]   rd_data;

    logic          col_ok, row_ok;
    logic          result_valid_reg;
    out_item_t     result_reg;
    logic          skid_valid_reg;
    out_item_t     skid_reg;
    out_item_t     fresh;

    assign adv          = !skid_valid_reg;
    assign item_stall   = !adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_sq_reg <= MAX_RANGE_SQ_RESET;
            min_forward_reg  <= MIN_FORWARD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_RANGE_SQ: max_range_sq_reg <= cfg_data;
                CFG_MIN_FORWARD:  min_forward_reg  <= cfg_data[30:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic [XW-1:0] wide_addr;
        logic [31:0]   mag [3];
        logic signed [63:0] sx [3];
        wide_addr = XW'(item.pixel_addr);
        sx[0] = {{32{item.sensor_x[31]}}, item.sensor_x};
        sx[1] = {{32{item.sensor_y[31]}}, item.sensor_y};
        sx[2] = {{32{item.sensor_z[31]}}, item.sensor_z};
        for (int i = 0; i < 3; i++)
        begin
            mag[i]     = sx[i][63] ? 32'(-sx[i]) : sx[i][31:0];
            sq_next[i] = 64'(mag[i]) * 64'(mag[i]);
        end
        p_next[0] = sx[0] * CAM_00;
        p_next[1] = sx[1] * CAM_01;
        p_next[2] = sx[2] * CAM_02;
        p_next[3] = sx[0] * CAM_10;
        p_next[4] = sx[1] * CAM_11;
        p_next[5] = sx[2] * CAM_12;
        p_next[6] = sx[0] * CAM_20;
        p_next[7] = sx[1] * CAM_21;
        p_next[8] = sx[2] * CAM_22;

        a_side_next        = '0;
        a_side_next.valid  = item_valid;
        a_side_next.is_pt  = item.mode == MODE_POINT;
        a_side_next.wr_ok  = wide_addr < XW'(DEPTH);
        a_side_next.fwd_ok = item.sensor_x > $signed({1'b0, min_forward_reg});
        a_side_next.wa     = wide_addr[AW-1:0];
        a_side_next.rgb    = {item.red, item.green, item.blue};
        a_side_next.map    = {item.map_x, item.map_y, item.map_z};
    end

    always_comb
    begin
        c_side_next        = b_side_reg;
        c_side_next.rng_ok = range_reg < {16'd0, max_range_sq_reg, 16'd0};
        c_side_next.dnz    = yd_reg != '0;
        c_side_next.neg_c  = y0_reg[63] ^ yd_reg[63];
        c_side_next.neg_r  = y1_reg[63] ^ yd_reg[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
            b_side_reg <= '0;
            c_side_reg <= '0;
        end
        else if (adv)
        begin
            a_side_reg <= a_side_next;
            b_side_reg <= a_side_reg;
            c_side_reg <= c_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p_reg[i] <= p_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            y0_reg    <= p_reg[0] + p_reg[1] + p_reg[2] + CAM_OFF_0;
            y1_reg    <= p_reg[3] + p_reg[4] + p_reg[5] + CAM_OFF_1;
            yd_reg    <= p_reg[6] + p_reg[7] + p_reg[8] + CAM_OFF_2;
            range_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            abs_c_reg <= y0_reg[63] ? 64'(-y0_reg) : 64'(y0_reg);
            abs_r_reg <= y1_reg[63] ? 64'(-y1_reg) : 64'(y1_reg);
            abs_d_reg <= yd_reg[63] ? 64'(-yd_reg) : 64'(yd_reg);
        end
    end

    lpc_div #(.QW(QW)) u_div_col (
        .clk (clk),
        .en  (adv),
        .num (abs_c_reg),
        .den (abs_d_reg),
        .quo (q_c),
        .ovf (ovf_c)
    );

    lpc_div #(.QW(QW)) u_div_row (
        .clk (clk),
        .en  (adv),
        .num (abs_r_reg),
        .den (abs_d_reg),
        .quo (q_r),
        .ovf (ovf_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            dl_reg[0] <= c_side_reg;
            for (int i = 1; i < L; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    assign d_side = dl_reg[L-1];

    always_comb
    begin
        col_ok = !ovf_c && (d_side.neg_c ? q_c == '0
                                         : (QW+1)'(q_c) < (QW+1)'(IMAGE_WIDTH));
        row_ok = !ovf_r && (d_side.neg_r ? q_r == '0
                                         : (QW+1)'(q_r) < (QW+1)'(IMAGE_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_we_reg    <= 1'b0;
            e_pt_reg    <= 1'b0;
            f_pt_reg    <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_side.valid;
            e_we_reg    <= d_side.valid && !d_side.is_pt && d_side.wr_ok;
            e_pt_reg    <= d_side.valid && d_side.is_pt && d_side.dnz && d_side.fwd_ok
                           && d_side.rng_ok && col_ok && row_ok;
            f_pt_reg    <= e_pt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_addr_reg <= d_side.is_pt ? AW'(q_r) * AW'(IMAGE_WIDTH) + AW'(q_c)
                                       : d_side.wa;
            e_rgb_reg  <= d_side.rgb;
            e_map_reg  <= d_side.map;
            f_map_reg  <= e_map_reg;
        end
    end

    lpc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_frame (
        .clk   (clk),
        .en    (adv && e_valid_reg),
        .we    (e_we_reg),
        .addr  (e_addr_reg),
        .wdata (e_rgb_reg),
        .rdata (rd_data)
    );

    assign fresh = {f_map_reg, rd_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!result_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (result_valid_reg && result_stall)
        begin
            skid_valid_reg <= f_pt_reg;
        end
        else
        begin
            result_valid_reg <= f_pt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!result_stall)
            begin
                result_reg <= skid_reg;
            end
        end
        else if (result_valid_reg && result_stall)
        begin
            skid_reg <= fresh;
        end
        else
        begin
            result_reg <= fresh;
        end
    end

endmodule

/* hdl/lpc_checker.sv */
module lpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input lpc_pkg::out_item_t result
);

    import lpc_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("Stalled result item was dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("Stalled result item changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("Input stalled while no result item was waiting.");

    assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("Result valid during reset.");

endmodule

bind lidar_point_colorizer lpc_checker u_lpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import lpc_pkg::*;

    localparam int IMG_W      = 640;
    localparam int IMG_H      = 480;
    localparam int NUM_PIXELS = IMG_W * IMG_H;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        in_item_t  item;
        bit        colored;
        out_item_t point;
    } pending_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_item_t item;
    logic result_valid;
    logic result_stall;
    out_item_t result;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pending_t pending_q[$];
    out_item_t colored_q[$];
    logic [23:0] frame[NUM_PIXELS];
    bit written[NUM_PIXELS];
    logic [31:0] range_limit;
    logic [30:0] forward_min;
    int sender_idle;
    int receiver_idle;
    int errors;
    int colored_seen;
    int pixel_count;
    int point_count;
    int hold_left;
    bit hold_done;

    lidar_point_colorizer u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned square_of(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    // Works out whether a point gets colored and which pixel it lands on.
    function automatic void project_point(input in_item_t it, output bit hit,
                                          output int addr);
        longint x, y, z, depth, col, row;
        longint unsigned range_sq, limit;
        x = it.sensor_x;
        y = it.sensor_y;
        z = it.sensor_z;
        hit = 0;
        addr = 0;
        depth = CAM_20 * x + CAM_21 * y + CAM_22 * z + CAM_OFF_2;
        if (depth == 0)
            return;
        col = (CAM_00 * x + CAM_01 * y + CAM_02 * z + CAM_OFF_0) / depth;
        row = (CAM_10 * x + CAM_11 * y + CAM_12 * z + CAM_OFF_1) / depth;
        range_sq = square_of(x) + square_of(y) + square_of(z);
        limit = {16'b0, range_limit, 16'b0};
        if (col < 0 || col >= IMG_W || row < 0 || row >= IMG_H)
            return;
        if (!(x > longint'(forward_min)))
            return;
        if (!(range_sq < limit))
            return;
        hit = 1;
        addr = int'(row) * IMG_W + int'(col);
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.mode = MODE_PIXEL;
        it.pixel_addr = PIX_ADDR_W'($urandom_range(NUM_PIXELS - 1));
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        it.sensor_x = $urandom;
        it.sensor_y = $urandom;
        it.sensor_z = $urandom;
        it.map_x = $urandom;
        it.map_y = $urandom;
        it.map_z = $urandom;
        return it;
    endfunction

    task automatic add_pixel(input in_item_t it);
        pending_t p;
        it.mode = MODE_PIXEL;
        if (it.pixel_addr < NUM_PIXELS)
        begin
            frame[it.pixel_addr] = {it.red, it.green, it.blue};
            written[it.pixel_addr] = 1;
        end
        p.item = it;
        p.colored = 0;
        p.point = '0;
        pending_q = {pending_q, p};
        pixel_count++;
    endtask

    // A point that would land on a never-written pixel gets that pixel written first.
    task automatic add_point(input in_item_t it);
        pending_t p;
        in_item_t px;
        bit hit;
        int addr;
        it.mode = MODE_POINT;
        project_point(it, hit, addr);
        if (hit && !written[addr])
        begin
            px = random_item();
            px.pixel_addr = PIX_ADDR_W'(addr);
            add_pixel(px);
        end
        p.item = it;
        p.colored = hit;
        p.point.out_x = it.map_x;
        p.point.out_y = it.map_y;
        p.point.out_z = it.map_z;
        {p.point.out_red, p.point.out_green, p.point.out_blue} = hit ? frame[addr] : 24'h0;
        pending_q = {pending_q, p};
        point_count++;
    endtask

    // Picks a sensor point that projects near a chosen pixel at a chosen distance.
    task automatic add_aimed_point(input real fwd);
        in_item_t it;
        real u, v;
        it = random_item();
        u = $urandom_range(IMG_W - 1) + 0.5;
        v = $urandom_range(IMG_H - 1) + 0.5;
        it.sensor_x = int'(fwd * 65536.0);
        it.sensor_y = int'((332.6 - u) / 615.3 * fwd * 65536.0);
        it.sensor_z = int'((252.2 - v) / 617.1 * fwd * 65536.0);
        add_point(it);
    endtask

    task automatic wait_drained();
        wait (pending_q.size() == 0 && colored_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_MAX_RANGE_SQ)
            range_limit = value;
        else
            forward_min = value[30:0];
    endtask

    task automatic set_limits(input logic [31:0] range_sq, input logic [30:0] fwd);
        write_cfg(CFG_MAX_RANGE_SQ, range_sq);
        write_cfg(CFG_MIN_FORWARD, {1'b0, fwd});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input real max_fwd);
        in_item_t it;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            it = random_item();
            if (pick < 30)
                add_pixel(it);
            else if (pick < 35)
            begin
                it.pixel_addr = PIX_ADDR_W'($urandom_range(2 ** PIX_ADDR_W - 1, NUM_PIXELS));
                add_pixel(it);
            end
            else if (pick < 85)
                add_aimed_point(0.05 + max_fwd * ($urandom_range(1000) / 1000.0));
            else
                add_point(it);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (pending_q[0].colored)
                    colored_q = {colored_q, pending_q[0].point};
                pending_q.delete(0);
            end
            if (item_valid && item_stall)
                item_valid <= 1'b1;
            else if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle)
            begin
                item_valid <= 1'b1;
                item <= pending_q[0].item;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (!hold_done && colored_seen >= 60)
        begin
            hold_left <= 300;
            hold_done <= 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < receiver_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            colored_seen <= colored_seen + 1;
            if (colored_q.size() == 0)
            begin
                $display("%0t: unexpected point, actual %p", $time, result);
                errors++;
            end
            else
            begin
                if (result.out_x !== colored_q[0].out_x)
                begin
                    $display("%0t: out_x expected %0d actual %0d", $time,
                             colored_q[0].out_x, result.out_x);
                    errors++;
                end
                if (result.out_y !== colored_q[0].out_y)
                begin
                    $display("%0t: out_y expected %0d actual %0d", $time,
                             colored_q[0].out_y, result.out_y);
                    errors++;
                end
                if (result.out_z !== colored_q[0].out_z)
                begin
                    $display("%0t: out_z expected %0d actual %0d", $time,
                             colored_q[0].out_z, result.out_z);
                    errors++;
                end
                if (result.out_red !== colored_q[0].out_red)
                begin
                    $display("%0t: out_red expected %0d actual %0d", $time,
                             colored_q[0].out_red, result.out_red);
                    errors++;
                end
                if (result.out_green !== colored_q[0].out_green)
                begin
                    $display("%0t: out_green expected %0d actual %0d", $time,
                             colored_q[0].out_green, result.out_green);
                    errors++;
                end
                if (result.out_blue !== colored_q[0].out_blue)
                begin
                    $display("%0t: out_blue expected %0d actual %0d", $time,
                             colored_q[0].out_blue, result.out_blue);
                    errors++;
                end
                colored_q.delete(0);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d items and %0d points outstanding",
                 pending_q.size(), colored_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        in_item_t it;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        colored_seen = 0;
        pixel_count = 0;
        point_count = 0;
        sender_idle = 38;
        receiver_idle = 49;
        range_limit = MAX_RANGE_SQ_RESET;
        forward_min = MIN_FORWARD_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_limits(MAX_RANGE_SQ_RESET, MIN_FORWARD_RESET);

        // Directed items: store corners, ignored addresses, field extremes and zero depth.
        it = random_item();
        it.pixel_addr = '0;
        {it.red, it.green, it.blue} = 24'hFFFFFF;
        add_pixel(it);
        it.pixel_addr = PIX_ADDR_W'(NUM_PIXELS - 1);
        {it.red, it.green, it.blue} = 24'h000000;
        add_pixel(it);
        it.pixel_addr = PIX_ADDR_W'(NUM_PIXELS);
        add_pixel(it);
        it.pixel_addr = '1;
        add_pixel(it);
        it = random_item();
        it.sensor_x = 32'sd19087;
        it.sensor_y = 32'sd0;
        it.sensor_z = -32'sd14694;
        add_point(it);
        for (int i = 0; i < 8; i++)
        begin
            it = random_item();
            it.sensor_x = (i & 1) ? 32'h7FFFFFFF : 32'h80000000;
            it.sensor_y = (i & 2) ? 32'h7FFFFFFF : 32'h80000000;
            it.sensor_z = (i & 4) ? 32'h7FFFFFFF : 32'h80000000;
            it.map_x = (i & 1) ? 32'h7FFFFFFF : 32'h80000000;
            it.map_y = (i & 2) ? 32'h7FFFFFFF : 32'h80000000;
            it.map_z = (i & 4) ? 32'h7FFFFFFF : 32'h80000000;
            add_point(it);
        end
        add_aimed_point(0.02);
        add_aimed_point(-3.0);
        add_aimed_point(19.9);
        add_aimed_point(25.0);
        random_phase(190, 15.0);
        wait_drained();

        sender_idle = 49;
        receiver_idle = 38;
        set_limits(32'hFFFFFFFF, 31'd0);
        add_aimed_point(0.0);
        add_aimed_point(150.0);
        random_phase(190, 60.0);
        wait_drained();

        set_limits(32'd0, 31'h7FFFFFFF);
        random_phase(30, 15.0);
        wait_drained();

        sender_idle = 0;
        receiver_idle = 0;
        set_limits($urandom_range(26214400, 655360), 31'($urandom_range(131072)));
        random_phase(190, 12.0);
        wait_drained();

        $display("Sent %0d pixel writes and %0d points under four limit settings;",
                 pixel_count, point_count);
        $display("%0d points came back colored.", colored_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
